// File: design/psg_pkg.sv
// Shared types and constants for the pulse/saw sound generator.
package psg_pkg;

    // channel selects
    localparam logic [1:0] CH_P1  = 2'd0;
    localparam logic [1:0] CH_P2  = 2'd1;
    localparam logic [1:0] CH_SAW = 2'd2;

    // register selects within a channel
    localparam logic [1:0] REG_CTRL   = 2'd0;
    localparam logic [1:0] REG_PER_LO = 2'd1;
    localparam logic [1:0] REG_PER_HI = 2'd2;

    // channel base addresses
    localparam logic [15:0] BASE_P1  = 16'h9000;
    localparam logic [15:0] BASE_P2  = 16'hA000;
    localparam logic [15:0] BASE_SAW = 16'hB000;

    localparam logic [3:0] SAW_CLEAR_STEPS = 4'd14;
    localparam logic [11:0] PULSE_MIN_PERIOD = 12'd8;

    // decoded item handed from front to back
    typedef struct packed {
        logic       tick;
        logic       wr_en;
        logic [1:0] chan;
        logic [1:0] reg_sel;
        logic [7:0] data;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic       pulse_one_level;
        logic       pulse_two_level;
        logic [4:0] saw_level;
        logic [3:0] pulse_one_volume;
        logic [3:0] pulse_two_volume;
        logic [3:0] saw_volume;
    } t_res;

endpackage

// File: design/pulse_saw_sound_generator.sv
// Top level of the two-pulse, one-sawtooth sound generator.
//
//  Channel   Handshake      Transfer when      Payload
//  input     push / full    push && !full      i_action, i_address, i_write_data
//  result    empty / pop    pop && !empty      o_pulse_*_level, o_saw_level, o_*_volume
//
// One item per cycle sustained while pop keeps up. A result passes through the command
// queue register, then the result queue register, before it shows on the result ports.
// The channel state and the result queue are written at the same edge; the result queue decouples the update from pop.
// Reset clears all channel state and both queues; no clearing pass.
// A stalled pop fills the result queue, then the command queue, then raises full.
module pulse_saw_sound_generator #(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_action,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        empty,
    input  logic        pop,
    output logic        o_pulse_one_level,
    output logic        o_pulse_two_level,
    output logic [4:0]  o_saw_level,
    output logic [3:0]  o_pulse_one_volume,
    output logic [3:0]  o_pulse_two_volume,
    output logic [3:0]  o_saw_volume
);

    psg_pkg::t_cmd cmd;
    psg_pkg::t_res res;
    logic          cmd_valid;
    logic          cmd_pop;

    psg_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_action     (i_action),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_cmd        (cmd),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_pop    (cmd_pop)
    );

    psg_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign o_pulse_one_level  = res.pulse_one_level;
    assign o_pulse_two_level  = res.pulse_two_level;
    assign o_saw_level        = res.saw_level;
    assign o_pulse_one_volume = res.pulse_one_volume;
    assign o_pulse_two_volume = res.pulse_two_volume;
    assign o_saw_volume       = res.saw_volume;

endmodule

// File: design/psg_fifo.sv
// Small synchronous queue used between the generator stages.
module psg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr, rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (wr && !rd) begin
            n_count = r_count + 1'b1;
        end else if (rd && !wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

// File: design/psg_front.sv
// Front end: takes items, decodes register writes and ticks, queues commands.
module psg_front #(
    parameter int CMD_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic          i_action,
    input  logic [15:0]   i_address,
    input  logic [7:0]    i_write_data,
    output psg_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop
);

    psg_pkg::t_cmd dec;
    logic          cmd_empty;
    logic [$bits(psg_pkg::t_cmd)-1:0] cmd_bits;

    always_comb begin
        dec         = '0;
        dec.tick    = i_action;
        dec.reg_sel = i_address[1:0];
        dec.data    = i_write_data;
        dec.chan    = psg_pkg::CH_P1;
        if (!i_action && i_address[1:0] <= psg_pkg::REG_PER_HI) begin
            if (i_address[15:2] == psg_pkg::BASE_P1[15:2]) begin
                dec.wr_en = 1'b1;
                dec.chan  = psg_pkg::CH_P1;
            end else if (i_address[15:2] == psg_pkg::BASE_P2[15:2]) begin
                dec.wr_en = 1'b1;
                dec.chan  = psg_pkg::CH_P2;
            end else if (i_address[15:2] == psg_pkg::BASE_SAW[15:2]) begin
                dec.wr_en = 1'b1;
                dec.chan  = psg_pkg::CH_SAW;
            end
        end
    end

    psg_fifo #(
        .WIDTH ($bits(psg_pkg::t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (dec),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_rdata (cmd_bits),
        .o_empty (cmd_empty)
    );

    assign o_cmd       = psg_pkg::t_cmd'(cmd_bits);
    assign o_cmd_valid = !cmd_empty;

endmodule

// File: design/psg_back.sv
// Back end: channel state, divider/step update and the result queue.
module psg_back #(
    parameter int RES_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  psg_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    output psg_pkg::t_res o_res,
    output logic          o_empty,
    input  logic          i_pop
);

    logic [11:0] r_count [3];
    logic [11:0] n_count [3];
    logic [11:0] r_period [3];
    logic [11:0] n_period [3];
    logic        r_enable [3];
    logic        n_enable [3];
    logic [3:0]  r_volume [3];
    logic [3:0]  n_volume [3];
    logic [2:0]  r_duty [2];
    logic [2:0]  n_duty [2];
    logic        r_const [2];
    logic        n_const [2];
    logic [3:0]  r_step [2];
    logic [3:0]  n_step [2];
    logic        r_pbit [2];
    logic        n_pbit [2];
    logic [5:0]  r_rate, n_rate;
    logic [7:0]  r_acc, n_acc;
    logic [3:0]  r_saw_sc, n_saw_sc;
    logic [4:0]  r_saw_out, n_saw_out;

    logic [11:0] cnt_inc [3];
    logic        hit [3];
    logic        pat_bit [2];
    logic [7:0]  acc_add;
    logic [3:0]  sc_inc;
    logic        res_full;
    logic        do_op;
    psg_pkg::t_res res;
    logic [$bits(psg_pkg::t_res)-1:0] res_bits;

    assign do_op     = i_cmd_valid && !res_full;
    assign o_cmd_pop = do_op;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            cnt_inc[ch] = r_enable[ch] ? r_count[ch] + 12'd1 : r_count[ch];
            hit[ch]     = (cnt_inc[ch] >= r_period[ch]);
        end
        for (int i = 0; i < 2; i++) begin
            // duty d is high on steps 1 .. d+1
            pat_bit[i] = r_const[i] ||
                         ((r_step[i] != 4'd0) && (r_step[i] <= {1'b0, r_duty[i]} + 4'd1));
        end
        acc_add = r_saw_sc[0] ? r_acc + {2'b00, r_rate} : r_acc;
        sc_inc  = r_saw_sc + 4'd1;
    end

    always_comb begin
        n_count   = r_count;
        n_period  = r_period;
        n_enable  = r_enable;
        n_volume  = r_volume;
        n_duty    = r_duty;
        n_const   = r_const;
        n_step    = r_step;
        n_pbit    = r_pbit;
        n_rate    = r_rate;
        n_acc     = r_acc;
        n_saw_sc  = r_saw_sc;
        n_saw_out = r_saw_out;
        if (do_op && i_cmd.tick) begin
            for (int ch = 0; ch < 3; ch++) begin
                n_count[ch] = hit[ch] ? 12'd0 : cnt_inc[ch];
            end
            for (int i = 0; i < 2; i++) begin
                if (hit[i]) begin
                    n_step[i] = r_step[i] + 4'd1;
                    n_pbit[i] = pat_bit[i] && (r_period[i] >= psg_pkg::PULSE_MIN_PERIOD);
                end
            end
            if (hit[2]) begin
                if (sc_inc == psg_pkg::SAW_CLEAR_STEPS) begin
                    n_saw_sc = 4'd0;
                    n_acc    = 8'd0;
                end else begin
                    n_saw_sc = sc_inc;
                    n_acc    = acc_add;
                end
                n_saw_out = (sc_inc == psg_pkg::SAW_CLEAR_STEPS) ? 5'd0 : acc_add[7:3];
            end
        end else if (do_op && i_cmd.wr_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (i_cmd.chan == 2'(ch)) begin
                    case (i_cmd.reg_sel)
                        psg_pkg::REG_CTRL: begin
                            n_volume[ch] = i_cmd.data[3:0];
                        end
                        psg_pkg::REG_PER_LO: begin
                            n_period[ch][7:0] = i_cmd.data;
                        end
                        psg_pkg::REG_PER_HI: begin
                            n_period[ch][11:8] = i_cmd.data[3:0];
                            n_enable[ch]       = i_cmd.data[7];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            if (i_cmd.reg_sel == psg_pkg::REG_CTRL) begin
                if (i_cmd.chan == psg_pkg::CH_SAW) begin
                    n_rate = i_cmd.data[5:0];
                end else begin
                    n_duty[i_cmd.chan[0]]  = i_cmd.data[6:4];
                    n_const[i_cmd.chan[0]] = i_cmd.data[7];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_count[ch]  <= '0;
                r_period[ch] <= '0;
                r_enable[ch] <= 1'b0;
                r_volume[ch] <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                r_duty[i]  <= '0;
                r_const[i] <= 1'b0;
                r_step[i]  <= '0;
                r_pbit[i]  <= 1'b0;
            end
            r_rate    <= '0;
            r_acc     <= '0;
            r_saw_sc  <= '0;
            r_saw_out <= '0;
        end else begin
            r_count   <= n_count;
            r_period  <= n_period;
            r_enable  <= n_enable;
            r_volume  <= n_volume;
            r_duty    <= n_duty;
            r_const   <= n_const;
            r_step    <= n_step;
            r_pbit    <= n_pbit;
            r_rate    <= n_rate;
            r_acc     <= n_acc;
            r_saw_sc  <= n_saw_sc;
            r_saw_out <= n_saw_out;
        end
    end

    // result reflects state after this item
    always_comb begin
        res.pulse_one_level  = n_pbit[0];
        res.pulse_two_level  = n_pbit[1];
        res.saw_level        = n_saw_out;
        res.pulse_one_volume = n_volume[0];
        res.pulse_two_volume = n_volume[1];
        res.saw_volume       = n_volume[2];
    end

    psg_fifo #(
        .WIDTH ($bits(psg_pkg::t_res)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (do_op),
        .i_wdata (res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_rdata (res_bits),
        .o_empty (o_empty)
    );

    assign o_res = psg_pkg::t_res'(res_bits);

endmodule

// File: design/psg_checker.sv
// Port-level checks for the sound generator, bound to the top level.
module psg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       o_pulse_one_level,
    input logic [4:0] o_saw_level
);

    // queues come out of reset drained
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not clear after reset");

    // an item taken while no result waits yields one once it has passed the command and result queues
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && empty) |=> ##1 !empty)
        else $error("result missing two cycles after transfer");

    // full only rises after an input transfer
    a_full_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && !full) |=> !$rose(full))
        else $error("full rose without an input transfer");

    // a waiting result stays put until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pulse_one_level) && $stable(o_saw_level)))
        else $error("waiting result changed before transfer");

endmodule

bind pulse_saw_sound_generator psg_checker u_psg_checker (.*);
